FILE: rtl/etf_pkg.sv
// ============================================================================
// etf_pkg - shared types and constants for the escape-time fractal pixel
// Fixed-point format, configuration register codes, queue entry and
// result layouts used across the front end, the iteration core and checker.
// ============================================================================
package etf_pkg;

    // fixed-point coordinate format (signed Q4.28)
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;

    // derived arithmetic widths
    localparam int PROD_W = 2 * COORD_WIDTH;          // full signed product
    localparam int SQ_W   = PROD_W - FRAC_BITS;       // product after shift
    localparam int EXT_W  = SQ_W + 2;                 // headroom for sums before clamp

    // register and field widths
    localparam int ITER_W      = 16;
    localparam int ITER_CNT_W  = ITER_W + 1;
    localparam int RADIUS_W    = 31;
    localparam int COLOR_W     = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // queue between front end and core
    localparam int QUEUE_DEPTH = 2;

    // reset values of the configuration registers
    localparam logic [ITER_W-1:0]   MAX_ITER_RST = ITER_W'(256);
    localparam logic [RADIUS_W-1:0] RADIUS_RST   = RADIUS_W'(32'h4000_0000);
    localparam logic [COLOR_W-1:0]  SPAN_RST     = COLOR_W'(255);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_ITER    = 3'd0,
        CFG_RADIUS_SQ   = 3'd1,
        CFG_PAL_OFFSET  = 3'd2,
        CFG_PAL_SPAN    = 3'd3,
        CFG_INSIDE      = 3'd4,
        CFG_JULIA_MODE  = 3'd5,
        CFG_CONST_RE    = 3'd6,
        CFG_CONST_IM    = 3'd7
    } t_cfg_index;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // classified request: starting orbit point and additive constant
    typedef struct packed {
        t_coord zr;
        t_coord zi;
        t_coord cr;
        t_coord ci;
    } t_job;

    // settings the front end needs for classification
    typedef struct packed {
        logic   julia_mode;
        t_coord const_re;
        t_coord const_im;
    } t_front_cfg;

    // settings the iteration core needs
    typedef struct packed {
        logic [ITER_W-1:0]   iter_limit;
        logic [RADIUS_W-1:0] escape_radius_sq;
        logic [COLOR_W-1:0]  pal_base;
        logic [COLOR_W-1:0]  pal_len;
        logic [COLOR_W-1:0]  inside_color;
    } t_core_cfg;

    // one finished pixel
    typedef struct packed {
        logic [COLOR_W-1:0]    pix_color;
        logic                  escaped;
        logic [ITER_CNT_W-1:0] iter_count;
    } t_result;

endpackage

FILE: rtl/etf_point_if.sv
// ============================================================================
// etf_point_if - pixel coordinate request channel
// Valid/ready handshake carrying one complex coordinate in signed Q4.28.
// ============================================================================
interface etf_point_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [etf_pkg::COORD_WIDTH-1:0] point_re;
    logic signed [etf_pkg::COORD_WIDTH-1:0] point_im;

    modport source (output valid, output point_re, output point_im, input ready);
    modport sink   (input valid, input point_re, input point_im, output ready);

endinterface

FILE: rtl/etf_color_if.sv
// ============================================================================
// etf_color_if - pixel color result channel
// Valid/ready handshake carrying palette index, escape flag and iteration.
// ============================================================================
interface etf_color_if;

    logic                             valid;
    logic                             ready;
    logic [etf_pkg::COLOR_W-1:0]      pix_color;
    logic                             escaped;
    logic [etf_pkg::ITER_CNT_W-1:0]   iter_count;

    modport source (output valid, output pix_color, output escaped, output iter_count,
                    input ready);
    modport sink   (input valid, input pix_color, input escaped, input iter_count,
                    output ready);

endinterface

FILE: rtl/etf_front.sv
// ============================================================================
// etf_front - request intake and classification
// Picks the orbit start and constant for Mandelbrot or Julia mode and
// holds classified requests in a short queue ahead of the iteration core.
// ============================================================================
module etf_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etf_pkg::t_front_cfg i_cfg,
    etf_point_if.sink           i_point,
    output logic                o_job_valid,
    output etf_pkg::t_job       o_job,
    input  logic                i_job_pop
);

    localparam int PTR_W = (etf_pkg::QUEUE_DEPTH > 1) ? $clog2(etf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(etf_pkg::QUEUE_DEPTH + 1);

    etf_pkg::t_job          r_slot [etf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]       r_count, n_count;
    etf_pkg::t_job          job_in;
    logic                   push;

    // classify: mandelbrot starts at zero with c = point, julia starts at the point
    always_comb begin
        if (i_cfg.julia_mode) begin
            job_in.zr = i_point.point_re;
            job_in.zi = i_point.point_im;
            job_in.cr = i_cfg.const_re;
            job_in.ci = i_cfg.const_im;
        end else begin
            job_in.zr = '0;
            job_in.zi = '0;
            job_in.cr = i_point.point_re;
            job_in.ci = i_point.point_im;
        end
    end

    assign i_point.ready = (r_count != CNT_W'(etf_pkg::QUEUE_DEPTH));
    assign push          = i_point.valid && i_point.ready;
    assign o_job_valid   = (r_count != '0);
    assign o_job         = r_slot[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(etf_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_job_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(etf_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_job_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_job_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= job_in;
        end
    end

endmodule

FILE: rtl/etf_core.sv
// ============================================================================
// etf_core - escape-time iteration engine
// Runs z = z^2 + c with three shared multipliers, tests the squared modulus
// and holds the finished color in an output stage.
// ============================================================================
module etf_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  etf_pkg::t_core_cfg i_cfg,
    input  logic               i_job_valid,
    input  etf_pkg::t_job      i_job,
    output logic               o_job_pop,
    etf_color_if.source        o_color
);

    localparam int W     = etf_pkg::COORD_WIDTH;
    localparam int F     = etf_pkg::FRAC_BITS;
    localparam int P_W   = etf_pkg::PROD_W;
    localparam int SQ_W  = etf_pkg::SQ_W;
    localparam int EXT_W = etf_pkg::EXT_W;
    localparam int K_W   = etf_pkg::ITER_CNT_W;
    localparam int C_W   = etf_pkg::COLOR_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_UPD  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                ov;
    } t_sat;

    t_state                 r_state, n_state;
    logic signed [W-1:0]    r_zr, r_zi, r_cr, r_ci;
    logic                   r_ov;
    logic [K_W-1:0]         r_k;
    logic [C_W-1:0]         r_step;
    logic signed [P_W-1:0]  r_prr, r_pii, r_pri;
    etf_pkg::t_result       r_res;
    etf_pkg::t_result       r_out;
    logic                   r_out_valid;

    logic signed [SQ_W-1:0] sq_rr, sq_ii, pr_ri;
    logic [SQ_W:0]          mag_sum;
    logic                   escape;
    logic signed [EXT_W-1:0] re_ext, im_ext;
    t_sat                   re_sat, im_sat;
    logic                   last_iter;
    logic [C_W-1:0]         step_inc;
    logic                   out_load;
    etf_pkg::t_result       res_inside;

    // saturate a wide sum to the coordinate range, flag when it clips
    function automatic t_sat clamp_coord(input logic signed [EXT_W-1:0] v);
        t_sat s;
        s.ov = (v[EXT_W-1:W-1] != '0) && (v[EXT_W-1:W-1] != '1);
        if (!s.ov) begin
            s.value = v[W-1:0];
        end else if (v[EXT_W-1]) begin
            s.value = {1'b1, {(W-1){1'b0}}};
        end else begin
            s.value = {1'b0, {(W-1){1'b1}}};
        end
        return s;
    endfunction

    // products shifted down with rounding toward minus infinity
    assign sq_rr   = $signed(r_prr[P_W-1:F]);
    assign sq_ii   = $signed(r_pii[P_W-1:F]);
    assign pr_ri   = $signed(r_pri[P_W-1:F]);

    // escape test on the squared modulus, or a saturated previous update
    assign mag_sum = (SQ_W+1)'(r_prr[P_W-1:F]) + (SQ_W+1)'(r_pii[P_W-1:F]);
    assign escape  = r_ov || (mag_sum > (SQ_W+1)'(i_cfg.escape_radius_sq));

    // next orbit point before saturation
    assign re_ext  = EXT_W'(sq_rr) - EXT_W'(sq_ii) + EXT_W'(r_cr);
    assign im_ext  = (EXT_W'(pr_ri) <<< 1) + EXT_W'(r_ci);
    assign re_sat  = clamp_coord(re_ext);
    assign im_sat  = clamp_coord(im_ext);

    assign last_iter = (r_k == K_W'(i_cfg.iter_limit));
    assign step_inc  = r_step + 1'b1;

    assign res_inside.pix_color   = i_cfg.inside_color;
    assign res_inside.escaped     = 1'b0;
    assign res_inside.iter_count  = K_W'(i_cfg.iter_limit) + 1'b1;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_color.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_cfg.iter_limit == '0) ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = (escape || last_iter) ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_color.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // orbit datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_zr   <= i_job.zr;
                r_zi   <= i_job.zi;
                r_cr   <= i_job.cr;
                r_ci   <= i_job.ci;
                r_ov   <= 1'b0;
                r_k    <= K_W'(1);
                r_step <= '0;
                r_res  <= res_inside;
            end
            S_MUL: begin
                r_prr <= r_zr * r_zr;
                r_pii <= r_zi * r_zi;
                r_pri <= r_zr * r_zi;
            end
            S_UPD: begin
                if (escape) begin
                    r_res.pix_color   <= i_cfg.pal_base + r_step;
                    r_res.escaped     <= 1'b1;
                    r_res.iter_count  <= r_k;
                end else begin
                    r_zr  <= re_sat.value;
                    r_zi  <= im_sat.value;
                    r_ov  <= r_ov || re_sat.ov || im_sat.ov;
                    r_k   <= r_k + 1'b1;
                    // iteration count modulo span, zero span wraps at 8 bits
                    r_step <= (step_inc == i_cfg.pal_len) ? '0 : step_inc;
                    r_res <= res_inside;
                end
            end
            default: begin
            end
        endcase
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_color.valid       = r_out_valid;
    assign o_color.pix_color   = r_out.pix_color;
    assign o_color.escaped     = r_out.escaped;
    assign o_color.iter_count  = r_out.iter_count;

endmodule

FILE: rtl/escape_time_fractal_pixel.sv
// iteration: each iteration is a multiply state on three shared 32x32 multipliers
// followed by an update/escape-test state, repeated until escape or, for an inside
// point, until the iteration limit
// flow: the core iterates one pixel at a time; a two-entry request queue and the
// output stage let requests and results flow while the core iterates
// reset: synchronous active low, clears control state and loads register defaults
// ============================================================================
// escape_time_fractal_pixel - Mandelbrot / Julia escape-time color of a point
// Configuration registers, request front end and iteration core.
// ============================================================================
module escape_time_fractal_pixel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [etf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [etf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    etf_point_if.sink                      i_point,
    etf_color_if.source                    o_color
);

    etf_pkg::t_core_cfg  r_core_cfg;
    etf_pkg::t_front_cfg r_front_cfg;
    logic                job_valid;
    etf_pkg::t_job       job;
    logic                job_pop;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_cfg.iter_limit       <= etf_pkg::MAX_ITER_RST;
            r_core_cfg.escape_radius_sq <= etf_pkg::RADIUS_RST;
            r_core_cfg.pal_base         <= '0;
            r_core_cfg.pal_len          <= etf_pkg::SPAN_RST;
            r_core_cfg.inside_color     <= '0;
            r_front_cfg.julia_mode      <= 1'b0;
            r_front_cfg.const_re        <= '0;
            r_front_cfg.const_im        <= '0;
        end else if (i_cfg_we) begin
            case (etf_pkg::t_cfg_index'(i_cfg_index))
                etf_pkg::CFG_MAX_ITER: begin
                    r_core_cfg.iter_limit <= i_cfg_data[etf_pkg::ITER_W-1:0];
                end
                etf_pkg::CFG_RADIUS_SQ: begin
                    r_core_cfg.escape_radius_sq <= i_cfg_data[etf_pkg::RADIUS_W-1:0];
                end
                etf_pkg::CFG_PAL_OFFSET: begin
                    r_core_cfg.pal_base <= i_cfg_data[etf_pkg::COLOR_W-1:0];
                end
                etf_pkg::CFG_PAL_SPAN: begin
                    r_core_cfg.pal_len <= i_cfg_data[etf_pkg::COLOR_W-1:0];
                end
                etf_pkg::CFG_INSIDE: begin
                    r_core_cfg.inside_color <= i_cfg_data[etf_pkg::COLOR_W-1:0];
                end
                etf_pkg::CFG_JULIA_MODE: begin
                    r_front_cfg.julia_mode <= i_cfg_data[0];
                end
                etf_pkg::CFG_CONST_RE: begin
                    r_front_cfg.const_re <= i_cfg_data[etf_pkg::COORD_WIDTH-1:0];
                end
                etf_pkg::CFG_CONST_IM: begin
                    r_front_cfg.const_im <= i_cfg_data[etf_pkg::COORD_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // request intake and queue
    etf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_front_cfg),
        .i_point     (i_point),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    // iteration engine and output stage
    etf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_core_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_color     (o_color)
    );

endmodule

FILE: rtl/etf_checker.sv
// ============================================================================
// etf_checker - port-level checks for the escape-time fractal pixel
// Tracks outstanding requests and shadow settings from the ports and checks
// result consistency; bound to the top level.
// ============================================================================
module etf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [etf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input logic [etf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [etf_pkg::COLOR_W-1:0]     i_pix_color,
    input logic                            i_escaped,
    input logic [etf_pkg::ITER_CNT_W-1:0]  i_iter_count
);

    logic [2:0]                     r_pending;
    logic [etf_pkg::ITER_W-1:0]     r_max_iter;
    logic [etf_pkg::COLOR_W-1:0]    r_inside;
    logic                           in_acc;
    logic                           out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // outstanding requests and shadow settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_max_iter <= etf_pkg::MAX_ITER_RST;
            r_inside   <= '0;
        end else begin
            r_pending <= r_pending + 3'(in_acc) - 3'(out_acc);
            if (i_cfg_we && (i_cfg_index == etf_pkg::CFG_MAX_ITER)) begin
                r_max_iter <= i_cfg_data[etf_pkg::ITER_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == etf_pkg::CFG_INSIDE)) begin
                r_inside <= i_cfg_data[etf_pkg::COLOR_W-1:0];
            end
        end
    end

    // no result without an outstanding request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != '0))
        else $error("result without outstanding request");

    // inside points carry the inside color and limit plus one
    a_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_escaped) |->
            (i_pix_color == r_inside) &&
            (i_iter_count == etf_pkg::ITER_CNT_W'(r_max_iter) + 1'b1))
        else $error("inside result inconsistent with settings");

    // escaped points stop within the iteration limit
    a_escape_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_escaped) |->
            (i_iter_count != '0) &&
            (i_iter_count <= etf_pkg::ITER_CNT_W'(r_max_iter)))
        else $error("escape iteration out of range");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            i_out_valid && $stable(i_pix_color) && $stable(i_escaped) &&
            $stable(i_iter_count))
        else $error("stalled result changed");

endmodule

bind escape_time_fractal_pixel etf_checker u_etf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_index   (i_cfg_index),
    .i_cfg_data    (i_cfg_data),
    .i_in_valid    (i_point.valid),
    .i_in_ready    (i_point.ready),
    .i_out_valid   (o_color.valid),
    .i_out_ready   (o_color.ready),
    .i_pix_color   (o_color.pix_color),
    .i_escaped     (o_color.escaped),
    .i_iter_count  (o_color.iter_count)
);
